[design/srrw_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
package srrw_pkg;

  localparam int unsigned SEQ_W        = 16;
  localparam int unsigned SLOT_STORE_W = 7;   // holds a remainder below 2*64
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam logic [SEQ_W-1:0] PROBE_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    VERDICT_PROBE    = 3'd0,
    VERDICT_CORRUPT  = 3'd1,
    VERDICT_OUTSIDE  = 3'd2,
    VERDICT_IN_ORDER = 3'd3,
    VERDICT_OUT_ORD  = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [SEQ_W-1:0] frame_seq;
    logic             frame_good;
    logic             frame_is_last;
  } frame_t;

  typedef struct packed {
    logic [SEQ_W-1:0] ack_seq;
    verdict_e         verdict;
    logic             store_now;
    logic [3:0]       store_slot;
    logic             flush_low_half;
    logic             flush_high_half;
    logic             transfer_done;
  } result_t;

  // Classified frame passed from front to back.
  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic                    good;
    logic                    is_last;
    logic                    is_probe;
    logic [SLOT_STORE_W-1:0] slot;
  } cmd_t;

endpackage

[design/selective_repeat_receive_window_core.sv]
// Selective-repeat receive window: top level with probe register and the three parts.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one parsed frame header
// per item: sequence number, integrity flag, last-frame flag. Output channel
// (out_valid_o/out_ready_i/out_item_o) returns exactly one result item per
// header: ack number, verdict, store flag and slot, half-flush flags and done.
// cfg_we_i/cfg_wdata_i write the probe number; write it only while idle.
// From input accept to output valid an item passes one front stage (masking,
// reciprocal quotient for the slot), one queue slot and one result register
// loaded by the back end. Throughput is one item per cycle unless the output
// stalls, set by the back end's window update (mask run count and slide).
// When out_ready_i is low the result register holds; the two-entry queue and
// the front stage keep taking items until they fill, then in_ready_o drops.
// Reset clears the window (next expected 1, empty mask, counters zero, not
// done) and sets the probe number to 65535; items are taken right after.
module selective_repeat_receive_window_core import srrw_pkg::*; #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  frame_t           in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_item_o,
  input  logic             cfg_we_i,
  input  logic [SEQ_W-1:0] cfg_wdata_i
);

  logic [SEQ_W-1:0] probe_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  cmd_t             push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= PROBE_RESET;
    end else if (cfg_we_i) begin
      probe_q <= cfg_wdata_i;
    end
  end

  srrw_front #(
    .WINDOW  (WINDOW),
    .SEQ_BITS(SEQ_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .probe_seq_i (probe_q),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  srrw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  srrw_back #(
    .WINDOW  (WINDOW),
    .SEQ_BITS(SEQ_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_cmd_i  (pop_cmd),
    .probe_seq_i(probe_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

[design/srrw_front.sv]
// Front end: accepts frame headers, masks the number, computes the slot, flags probes.
module srrw_front import srrw_pkg::*; #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  frame_t           in_item_i,
  input  logic [SEQ_W-1:0] probe_seq_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output cmd_t             push_cmd_o
);

  localparam longint unsigned DIV   = 64'(2 * WINDOW);
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + DIV - 64'd1) / DIV;
  localparam longint unsigned ALL1_MOD = ((64'd1 << SEQ_BITS) - 64'd1) % DIV;
  localparam logic [SEQ_W-1:0] SEQ_MASK16 =
    (SEQ_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SEQ_BITS) - 32'd1);

  logic                 s1_valid_q, s1_valid_d;
  logic [SEQ_W-1:0]     seq_q;
  logic                 good_q, last_q, zero_q;
  logic [SEQ_W-1:0]     quot_q;
  logic [SEQ_W-1:0]     seq_m, v_in, v_s1;
  logic [SEQ_W+RECIP_SHIFT-1:0] prod;
  logic [SEQ_W-1:0]     rem_full;
  logic                 accept;

  assign seq_m  = in_item_i.frame_seq & SEQ_MASK16;
  assign v_in   = seq_m - SEQ_W'(1);
  // quotient by reciprocal; exact for 16-bit dividends at this shift
  assign prod   = (SEQ_W+RECIP_SHIFT)'(v_in) * (SEQ_W+RECIP_SHIFT)'(RECIP);

  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q  <= seq_m;
      good_q <= in_item_i.frame_good;
      last_q <= in_item_i.frame_is_last;
      zero_q <= (seq_m == '0);
      quot_q <= prod[SEQ_W+RECIP_SHIFT-1:RECIP_SHIFT];
    end
  end

  assign v_s1     = seq_q - SEQ_W'(1);
  assign rem_full = v_s1 - SEQ_W'(quot_q * SEQ_W'(DIV));

  always_comb begin
    push_cmd_o.seq      = seq_q;
    push_cmd_o.good     = good_q;
    push_cmd_o.is_last  = last_q;
    push_cmd_o.is_probe = (seq_q == (probe_seq_i & SEQ_MASK16));
    // number zero wraps to all ones in the sequence space
    push_cmd_o.slot     = zero_q ? SLOT_STORE_W'(ALL1_MOD) : rem_full[SLOT_STORE_W-1:0];
  end

  assign push_valid_o = s1_valid_q;

endmodule

[design/srrw_queue.sv]
// Short queue of classified frames between front and back.
module srrw_queue import srrw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[design/srrw_back.sv]
// Back end: window state, slide over received runs, half flushes, result register.
module srrw_back import srrw_pkg::*; #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  cmd_t             pop_cmd_i,
  input  logic [SEQ_W-1:0] probe_seq_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_item_o
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [WINDOW-1:0]   mask_q, mask_d, mask_new;
  logic [SEQ_BITS-1:0] ne_q, ne_d;
  logic                last_q, last_d;
  logic [CNT_W-1:0]    rem_q, rem_d, rem_set, rem_slid;
  logic [CNT_W-1:0]    low_q, low_d, low_tmp;
  logic [CNT_W-1:0]    high_q, high_d, high_tmp;
  logic                done_q, done_d;
  logic                out_valid_q;
  result_t             out_q, res;

  logic [SEQ_BITS-1:0] seq_sb, offset, ack_sb;
  logic [31:0]         ack32;
  logic [IDX_W-1:0]    idx;
  logic                in_win, accepted, fresh, in_order, low_half, flush_lo, flush_hi;
  logic [CNT_W-1:0]    run;
  logic                run_open;
  logic                pop;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  assign seq_sb   = SEQ_BITS'(pop_cmd_i.seq);
  assign offset   = seq_sb - ne_q;
  assign in_win   = offset < SEQ_BITS'(WINDOW);
  assign idx      = offset[IDX_W-1:0];
  assign accepted = !pop_cmd_i.is_probe && pop_cmd_i.good && in_win;
  assign fresh    = accepted && !mask_q[idx];
  assign in_order = accepted && (offset == '0);
  assign mask_new = fresh ? (mask_q | (WINDOW'(1) << idx)) : mask_q;
  assign low_half = 32'(pop_cmd_i.slot) < 32'(WINDOW);

  // length of the run of received frames starting at next expected
  always_comb begin
    run      = '0;
    run_open = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      if (run_open && mask_new[i]) begin
        run = run + CNT_W'(1);
      end else begin
        run_open = 1'b0;
      end
    end
  end

  always_comb begin
    last_d   = last_q | (accepted && pop_cmd_i.is_last);
    rem_set  = (accepted && pop_cmd_i.is_last) ? CNT_W'(idx) + CNT_W'(1) : rem_q;
    rem_slid = (run >= rem_set) ? '0 : rem_set - run;
    rem_d    = (in_order && last_d) ? rem_slid : rem_set;
    mask_d   = in_order ? (mask_new >> run) : mask_new;
    ne_d     = in_order ? ne_q + SEQ_BITS'(run) : ne_q;
    done_d   = done_q | (in_order && last_d && (rem_slid == '0));

    low_tmp  = low_q + CNT_W'(fresh && low_half);
    high_tmp = high_q + CNT_W'(fresh && !low_half);
    flush_lo = accepted && (low_tmp == CNT_W'(WINDOW));
    flush_hi = accepted && (high_tmp == CNT_W'(WINDOW));
    low_d    = flush_lo ? '0 : low_tmp;
    high_d   = flush_hi ? '0 : high_tmp;
  end

  assign ack_sb = ne_d - SEQ_BITS'(1);
  assign ack32  = 32'(ack_sb);

  always_comb begin
    res.ack_seq         = pop_cmd_i.is_probe ? probe_seq_i : ack32[SEQ_W-1:0];
    res.store_now       = fresh;
    res.store_slot      = accepted ? pop_cmd_i.slot[3:0] : 4'd0;
    res.flush_low_half  = flush_lo;
    res.flush_high_half = flush_hi;
    res.transfer_done   = done_d;
    if (pop_cmd_i.is_probe) begin
      res.verdict = VERDICT_PROBE;
    end else if (!pop_cmd_i.good) begin
      res.verdict = VERDICT_CORRUPT;
    end else if (!in_win) begin
      res.verdict = VERDICT_OUTSIDE;
    end else if (in_order) begin
      res.verdict = VERDICT_IN_ORDER;
    end else begin
      res.verdict = VERDICT_OUT_ORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      ne_q        <= SEQ_BITS'(1);
      last_q      <= 1'b0;
      rem_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mask_q <= mask_d;
        ne_q   <= ne_d;
        last_q <= last_d;
        rem_q  <= rem_d;
        low_q  <= low_d;
        high_q <= high_d;
        done_q <= done_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/srrw_checker.sv]
// Port-level checks for the receive window, bound to the top level.
module srrw_checker import srrw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input result_t          out_item_o
);

  // done never clears once reported
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_item_o.transfer_done)
      |=> (!out_valid_o || out_item_o.transfer_done))
    else $error("transfer_done dropped after being reported");

  // only accepted frames may ask for storage
  a_store_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.store_now)
      |-> (out_item_o.verdict == VERDICT_IN_ORDER || out_item_o.verdict == VERDICT_OUT_ORD))
    else $error("store_now on a frame that was not accepted");

  // a half flush follows only from a newly stored frame
  a_flush_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.flush_low_half || out_item_o.flush_high_half))
      |-> out_item_o.store_now)
    else $error("half flush without a newly stored frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result item changed or vanished");

endmodule

bind selective_repeat_receive_window_core srrw_checker u_srrw_checker (.*);
